FILE: src/lrf_pkg.sv
// Shared types, constants and address decode for the LCD register file.
package lrf_pkg;

	localparam int DOTS_PER_LINE  = 456;
	localparam int DOTS_PER_FRAME = 70224;
	localparam int VBLANK_LINE    = 144;

	localparam int DOT_W   = 9;
	localparam int LINE_W  = 8;
	localparam int FRAME_W = DOT_W + LINE_W + 1;

	localparam int VRAM_DEPTH = 8192;
	localparam int VRAM_AW    = 13;
	localparam int OAM_DEPTH  = 160;
	localparam int OAM_AW     = 8;

	localparam logic [2:0]  VRAM_TOP  = 3'b100;
	localparam logic [7:0]  OAM_PAGE  = 8'hFE;
	localparam logic [7:0]  OAM_LIMIT = 8'(OAM_DEPTH);

	localparam logic [15:0] ADDR_CTRL = 16'hFF40;
	localparam logic [15:0] ADDR_STAT = 16'hFF41;
	localparam logic [15:0] ADDR_SCY  = 16'hFF42;
	localparam logic [15:0] ADDR_SCX  = 16'hFF43;
	localparam logic [15:0] ADDR_LY   = 16'hFF44;
	localparam logic [15:0] ADDR_BGP  = 16'hFF47;
	localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
	localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
	localparam logic [15:0] ADDR_WY   = 16'hFF4A;
	localparam logic [15:0] ADDR_WX   = 16'hFF4B;

	localparam logic [7:0] STATUS_WRITE_MASK = 8'b1111_1100;
	localparam int         ENABLE_BIT        = 7;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		RG_NONE,
		RG_VRAM,
		RG_OAM,
		RG_CTRL,
		RG_STAT,
		RG_SCY,
		RG_SCX,
		RG_LY,
		RG_BGP,
		RG_OBP0,
		RG_OBP1,
		RG_WY,
		RG_WX
	} region_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] address;
		logic [7:0]  write_data;
	} req_word_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       bad_access;
		logic [7:0] current_line;
		logic       vblank_pending;
	} rsp_word_t;

	typedef struct packed {
		logic               rd;
		logic               wr;
		logic               oam;
		logic [VRAM_AW-1:0] addr;
		logic [7:0]         wdata;
	} mem_req_t;

	typedef struct packed {
		logic [LINE_W-1:0] line;
		logic              vblank;
	} tmr_state_t;

	function automatic region_t decode(input logic [15:0] a);
		region_t r;
		r = RG_NONE;
		if (a[15:13] == VRAM_TOP) begin
			r = RG_VRAM;
		end else if (a[15:8] == OAM_PAGE && a[7:0] < OAM_LIMIT) begin
			r = RG_OAM;
		end else begin
			unique case (a)
				ADDR_CTRL: r = RG_CTRL;
				ADDR_STAT: r = RG_STAT;
				ADDR_SCY:  r = RG_SCY;
				ADDR_SCX:  r = RG_SCX;
				ADDR_LY:   r = RG_LY;
				ADDR_BGP:  r = RG_BGP;
				ADDR_OBP0: r = RG_OBP0;
				ADDR_OBP1: r = RG_OBP1;
				ADDR_WY:   r = RG_WY;
				ADDR_WX:   r = RG_WX;
				default:   r = RG_NONE;
			endcase
		end
		return r;
	endfunction

endpackage

FILE: src/lcd_register_file_line_timer.sv
// Top level of the LCD register file and line timer.
//
//   channel | signals                  | direction | word
//   req     | req_valid req_stall req  | in        | command, address, write_data
//   rsp     | rsp_valid rsp_stall rsp  | out       | read_data, bad_access, line, vblank
//
// One word per cycle unless stalled; responses pass stage one and the output register.
// The memory read port sets the latency: read data is registered in the RAM.
// After reset the memories are swept to zero; req_stall stays high meanwhile.
// A stalled response holds in the output register; one more word waits in stage one.
module lcd_register_file_line_timer
	import lrf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	logic       accept;
	logic       adv;
	region_t    region;
	mem_req_t   mreq;
	logic [7:0] mem_rdata;
	logic       mem_ready;
	logic       tick;
	tmr_state_t tmr;
	logic       is_read;
	logic       is_write;

	logic [7:0] ctrl_q, stat_q, scy_q, scx_q, bgp_q, obp0_q, obp1_q, wy_q, wx_q;

	logic       stg_valid_s1;
	logic       stg_mem_s1;
	rsp_word_t  stg_word_s1;
	logic       rsp_valid_q;
	rsp_word_t  rsp_q;

	logic [7:0] rd_c;
	logic       bad_c;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = !mem_ready || (stg_valid_s1 && !adv);
	assign accept    = req_valid && !req_stall;
	assign region    = decode(req.address);
	assign is_read   = req.command == CMD_READ;
	assign is_write  = req.command == CMD_WRITE;
	assign tick      = accept && req.command == CMD_TICK && ctrl_q[ENABLE_BIT];

	assign mreq.rd    = accept && is_read && (region == RG_VRAM || region == RG_OAM);
	assign mreq.wr    = accept && is_write && (region == RG_VRAM || region == RG_OAM);
	assign mreq.oam   = region == RG_OAM;
	assign mreq.addr  = req.address[VRAM_AW-1:0];
	assign mreq.wdata = req.write_data;

	lrf_vram u_vram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (mem_rdata),
		.ready  (mem_ready)
	);

	lrf_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.nxt    (tmr)
	);

	always_comb begin
		rd_c  = '0;
		bad_c = 1'b0;
		if (is_read) begin
			unique case (region)
				RG_CTRL: rd_c = ctrl_q;
				RG_STAT: rd_c = stat_q;
				RG_SCY:  rd_c = scy_q;
				RG_SCX:  rd_c = scx_q;
				RG_LY:   rd_c = tmr.line;
				RG_BGP:  rd_c = bgp_q;
				RG_OBP0: rd_c = obp0_q;
				RG_OBP1: rd_c = obp1_q;
				RG_WY:   rd_c = wy_q;
				RG_WX:   rd_c = wx_q;
				RG_NONE: bad_c = 1'b1;
				default: rd_c = '0;
			endcase
		end else if (is_write) begin
			bad_c = region == RG_NONE || region == RG_LY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
			stat_q <= '0;
			scy_q  <= '0;
			scx_q  <= '0;
			bgp_q  <= '0;
			obp0_q <= '0;
			obp1_q <= '0;
			wy_q   <= '0;
			wx_q   <= '0;
		end else if (accept && is_write) begin
			unique case (region)
				RG_CTRL: ctrl_q <= req.write_data;
				RG_STAT: stat_q <= req.write_data & STATUS_WRITE_MASK;
				RG_SCY:  scy_q  <= req.write_data;
				RG_SCX:  scx_q  <= req.write_data;
				RG_BGP:  bgp_q  <= req.write_data;
				RG_OBP0: obp0_q <= req.write_data;
				RG_OBP1: obp1_q <= req.write_data;
				RG_WY:   wy_q   <= req.write_data;
				RG_WX:   wx_q   <= req.write_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_valid_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				stg_valid_s1 <= 1'b1;
			end else if (adv) begin
				stg_valid_s1 <= 1'b0;
			end
			if (adv) begin
				rsp_valid_q <= stg_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stg_mem_s1  <= mreq.rd;
			stg_word_s1 <= '{read_data: rd_c, bad_access: bad_c,
				current_line: tmr.line, vblank_pending: tmr.vblank};
		end
		if (adv && stg_valid_s1) begin
			rsp_q <= '{read_data: stg_mem_s1 ? mem_rdata : stg_word_s1.read_data,
				bad_access: stg_word_s1.bad_access,
				current_line: stg_word_s1.current_line,
				vblank_pending: stg_word_s1.vblank_pending};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_vblank_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		tmr.vblank |=> tmr.vblank)
		else $error("vblank flag dropped");

	a_bad_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.bad_access |-> rsp.read_data == 8'd0)
		else $error("bad access carries data");

	a_line_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		32'(tmr.line) * 32'(DOTS_PER_LINE) < 32'(DOTS_PER_FRAME))
		else $error("line past end of frame");

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		!mem_ready |=> !stg_valid_s1 || $past(stg_valid_s1))
		else $error("word entered during memory sweep");
`endif

endmodule

FILE: src/lrf_vram.sv
// Tile and sprite attribute memories with clearing sweep after reset.
module lrf_vram
	import lrf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  mem_req_t   req,
	output logic [7:0] rdata,
	output logic       ready
);

	logic [7:0]         vram_mem [VRAM_DEPTH];
	logic [7:0]         oam_mem  [OAM_DEPTH];
	logic [VRAM_AW:0]   clr_q;
	logic [7:0]         rdata_q;
	logic               busy;
	logic               wr_vram;
	logic               wr_oam;
	logic [VRAM_AW-1:0] wr_addr;
	logic [7:0]         wr_data;

	assign busy  = !clr_q[VRAM_AW];
	assign ready = !busy;

	always_comb begin
		if (busy) begin
			wr_addr = clr_q[VRAM_AW-1:0];
			wr_data = '0;
			wr_vram = 1'b1;
			wr_oam  = clr_q[VRAM_AW-1:0] < VRAM_AW'(OAM_DEPTH);
		end else begin
			wr_addr = req.addr;
			wr_data = req.wdata;
			wr_vram = req.wr && !req.oam;
			wr_oam  = req.wr && req.oam;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_vram) begin
			vram_mem[wr_addr] <= wr_data;
		end
		if (wr_oam) begin
			oam_mem[wr_addr[OAM_AW-1:0]] <= wr_data;
		end
		if (req.rd) begin
			rdata_q <= req.oam ? oam_mem[req.addr[OAM_AW-1:0]] : vram_mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/lrf_timer.sv
// Dot and line counters with frame wrap and sticky vblank flag.
module lrf_timer
	import lrf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       tick,
	output tmr_state_t nxt
);

	logic [DOT_W-1:0]  dot_q;
	logic [LINE_W-1:0] line_q;
	logic              vblank_q;
	logic [DOT_W:0]    dot_inc;
	logic [DOT_W-1:0]  dot_a;
	logic [LINE_W-1:0] line_a;
	logic [FRAME_W-1:0] pos;
	logic [DOT_W-1:0]  dot_n;
	logic [LINE_W-1:0] line_n;
	logic              vblank_n;

	always_comb begin
		dot_inc = {1'b0, dot_q} + 1'b1;
		if (dot_inc >= (DOT_W+1)'(DOTS_PER_LINE)) begin
			dot_a  = '0;
			line_a = line_q + 1'b1;
		end else begin
			dot_a  = dot_inc[DOT_W-1:0];
			line_a = line_q;
		end
		pos = FRAME_W'(line_a) * FRAME_W'(DOTS_PER_LINE) + FRAME_W'(dot_a);
		if (pos >= FRAME_W'(DOTS_PER_FRAME)) begin
			dot_a  = '0;
			line_a = '0;
		end
		if (tick) begin
			dot_n    = dot_a;
			line_n   = line_a;
			vblank_n = vblank_q || (line_a == LINE_W'(VBLANK_LINE));
		end else begin
			dot_n    = dot_q;
			line_n   = line_q;
			vblank_n = vblank_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q    <= '0;
			line_q   <= '0;
			vblank_q <= 1'b0;
		end else begin
			dot_q    <= dot_n;
			line_q   <= line_n;
			vblank_q <= vblank_n;
		end
	end

	assign nxt = '{line: line_n, vblank: vblank_n};

endmodule
